>>> sv/jse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character constants and helpers shared by the string escaper blocks.
// ----------------------------------------------------------------------------
package jse_pkg;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       end_of_text_out;
    } out_item_t;

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_SHORT,
        KIND_UNICODE
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       eot;
    } entry_t;

    localparam int IDX_W = 3;

    localparam logic [IDX_W-1:0] POS_BSLASH = 3'd0;
    localparam logic [IDX_W-1:0] POS_U      = 3'd1;
    localparam logic [IDX_W-1:0] POS_ZERO_A = 3'd2;
    localparam logic [IDX_W-1:0] POS_ZERO_B = 3'd3;
    localparam logic [IDX_W-1:0] POS_HEX_HI = 3'd4;
    localparam logic [IDX_W-1:0] POS_HEX_LO = 3'd5;
    localparam logic [IDX_W-1:0] SHORT_LAST = 3'd1;
    localparam logic [IDX_W-1:0] UNI_LAST   = 3'd5;

    localparam logic [7:0] CHAR_QUOTE  = 8'h22;
    localparam logic [7:0] CHAR_BSLASH = 8'h5C;
    localparam logic [7:0] CHAR_APOS   = 8'h27;
    localparam logic [7:0] CTRL_MAX    = 8'h1F;
    localparam logic [7:0] CHAR_BS     = 8'h08;
    localparam logic [7:0] CHAR_FF     = 8'h0C;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_TAB    = 8'h09;
    localparam logic [7:0] CHAR_B      = 8'h62;
    localparam logic [7:0] CHAR_F      = 8'h66;
    localparam logic [7:0] CHAR_N      = 8'h6E;
    localparam logic [7:0] CHAR_R      = 8'h72;
    localparam logic [7:0] CHAR_T      = 8'h74;
    localparam logic [7:0] CHAR_U      = 8'h75;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_A      = 8'h61;

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] res;
        if (nib < 4'd10)
        begin
            res = CHAR_ZERO + {4'd0, nib};
        end
        else
        begin
            res = CHAR_A + {4'd0, nib} - 8'd10;
        end
        return res;
    endfunction

endpackage

>>> sv/jse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_front
// Classifies each incoming byte into pass-through, two-byte or unicode escape.
// ----------------------------------------------------------------------------
module jse_front (
    input  jse_pkg::in_item_t item,
    output jse_pkg::entry_t   entry
);
    import jse_pkg::*;

    always_comb
    begin
        entry.eot  = item.end_of_text;
        entry.data = item.in_byte;
        entry.kind = KIND_PASS;
        unique case (item.in_byte)
            CHAR_QUOTE:  begin entry.kind = KIND_SHORT; entry.data = CHAR_QUOTE;  end
            CHAR_BSLASH: begin entry.kind = KIND_SHORT; entry.data = CHAR_BSLASH; end
            CHAR_BS:     begin entry.kind = KIND_SHORT; entry.data = CHAR_B;      end
            CHAR_FF:     begin entry.kind = KIND_SHORT; entry.data = CHAR_F;      end
            CHAR_LF:     begin entry.kind = KIND_SHORT; entry.data = CHAR_N;      end
            CHAR_CR:     begin entry.kind = KIND_SHORT; entry.data = CHAR_R;      end
            CHAR_TAB:    begin entry.kind = KIND_SHORT; entry.data = CHAR_T;      end
            default:
            begin
                if (item.in_byte == CHAR_APOS || item.in_byte <= CTRL_MAX)
                begin
                    entry.kind = KIND_UNICODE;
                end
            end
        endcase
    end

endmodule

>>> sv/jse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_queue
// Small register queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module jse_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jse_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output jse_pkg::entry_t head_entry
);
    import jse_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

endmodule

>>> sv/jse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jse_back
// Walks through the escape run of the head entry, one output byte per cycle while out_ready allows.
// ----------------------------------------------------------------------------
module jse_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  jse_pkg::entry_t    head_entry,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output jse_pkg::out_item_t out_data
);
    import jse_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;
    logic             load;
    logic             run_last;
    logic [7:0]       run_byte;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign pop       = load && run_last;

    always_comb
    begin
        run_byte = head_entry.data;
        run_last = 1'b1;
        case (head_entry.kind)
            KIND_PASS:
            begin
                run_byte = head_entry.data;
                run_last = 1'b1;
            end
            KIND_SHORT:
            begin
                run_byte = (idx_reg == POS_BSLASH) ? CHAR_BSLASH : head_entry.data;
                run_last = (idx_reg == SHORT_LAST);
            end
            KIND_UNICODE:
            begin
                run_last = (idx_reg == UNI_LAST);
                unique case (idx_reg)
                    POS_BSLASH: run_byte = CHAR_BSLASH;
                    POS_U:      run_byte = CHAR_U;
                    POS_ZERO_A: run_byte = CHAR_ZERO;
                    POS_ZERO_B: run_byte = CHAR_ZERO;
                    POS_HEX_HI: run_byte = hex_digit(head_entry.data[7:4]);
                    POS_HEX_LO: run_byte = hex_digit(head_entry.data[3:0]);
                    default:    run_byte = head_entry.data;
                endcase
            end
            default:
            begin
                run_byte = head_entry.data;
                run_last = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load)
        begin
            out_valid_next                = 1'b1;
            out_data_next.out_byte        = run_byte;
            out_data_next.last            = run_last;
            out_data_next.end_of_text_out = run_last && head_entry.eot;
            idx_next                      = run_last ? '0 : idx_reg + 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    a_run_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != '0) |-> head_valid)
        else $error("run in progress without a head entry");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= UNI_LAST)
        else $error("run index past end of unicode escape");

    a_short_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head_entry.kind == KIND_SHORT) |-> (idx_reg <= SHORT_LAST))
        else $error("run index past end of short escape");

    a_pass_single: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head_entry.kind == KIND_PASS) |-> (idx_reg == '0))
        else $error("pass-through byte with nonzero run index");

endmodule

>>> sv/js_string_escaper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// js_string_escaper_core
// Byte stream to JavaScript/JSON escaped byte stream, one run per input byte.
// ----------------------------------------------------------------------------
// Each accepted byte produces a run of 1, 2 or 6 output bytes, the final one
// flagged by last and carrying end_of_text. The output sequencer emits one
// byte per cycle while out_ready allows, which sets the sustained rate, so
// plain text streams at one byte per cycle unless the output stalls. A
// QUEUE_DEPTH-entry queue sits between the classifier and the sequencer, so
// input is taken every cycle while it has room; an input transfer is written
// into the queue, and its first output byte is then registered in the
// sequencer's output register.
module js_string_escaper_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  jse_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output jse_pkg::out_item_t out_data
);
    import jse_pkg::*;

    entry_t cls_entry;
    entry_t head_entry;
    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   head_valid;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    jse_front u_front (
        .item  (in_data),
        .entry (cls_entry)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (cls_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule
